// ===== design/slru_pkg.sv =====
// Shared types for the set-associative LRU cache model.
package slru_pkg;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    // Outcome of one set lookup
    typedef struct packed {
        logic hit;
        logic evicted;
    } t_lookup;

endpackage

// ===== design/slru_set_update.sv =====
// Tag compare, LRU victim choice and rank update for one cache set.
module slru_set_update #(
    parameter int NUM_WAYS = 4,
    parameter int TAG_W    = 23,
    parameter int RANK_W   = 2
) (
    input  logic [NUM_WAYS-1:0]             i_valid,
    input  logic [NUM_WAYS-1:0][RANK_W-1:0] i_rank,
    input  logic [NUM_WAYS-1:0][TAG_W-1:0]  i_tag,
    input  logic [TAG_W-1:0]                i_look_tag,
    output logic [NUM_WAYS-1:0]             o_valid,
    output logic [NUM_WAYS-1:0][RANK_W-1:0] o_rank,
    output logic [NUM_WAYS-1:0][TAG_W-1:0]  o_tag,
    output slru_pkg::t_lookup               o_res
);

    localparam int WAY_IW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    always_comb begin
        logic              hit_f;
        logic              free_f;
        logic              lru_f;
        logic [WAY_IW-1:0] hit_w;
        logic [WAY_IW-1:0] free_w;
        logic [WAY_IW-1:0] lru_w;
        logic [WAY_IW-1:0] tgt_w;
        logic [RANK_W:0]   limit;

        hit_f  = 1'b0;
        free_f = 1'b0;
        lru_f  = 1'b0;
        hit_w  = '0;
        free_w = '0;
        lru_w  = '0;

        // parallel compare over the ways; last match wins, first free wins
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_valid[w]) begin
                if (i_tag[w] == i_look_tag) begin
                    hit_f = 1'b1;
                    hit_w = WAY_IW'(w);
                end
                if (i_rank[w] == RANK_W'(NUM_WAYS - 1)) begin
                    lru_f = 1'b1;
                    lru_w = WAY_IW'(w);
                end
            end else if (!free_f) begin
                free_f = 1'b1;
                free_w = WAY_IW'(w);
            end
        end

        // aging limit and the way that becomes most recent
        if (hit_f) begin
            limit = {1'b0, i_rank[hit_w]};
            tgt_w = hit_w;
        end else if (free_f) begin
            limit = (RANK_W+1)'(NUM_WAYS);
            tgt_w = free_w;
        end else begin
            limit = (RANK_W+1)'(NUM_WAYS - 1);
            tgt_w = lru_f ? lru_w : '0;
        end

        o_valid = i_valid;
        o_tag   = i_tag;
        o_rank  = i_rank;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_valid[w] && ({1'b0, i_rank[w]} < limit)) begin
                o_rank[w] = i_rank[w] + RANK_W'(1);
            end
        end

        o_valid[tgt_w] = 1'b1;
        o_tag[tgt_w]   = i_look_tag;
        o_rank[tgt_w]  = '0;

        o_res.hit     = hit_f;
        o_res.evicted = !hit_f && !free_f;
    end

endmodule

// ===== design/set_assoc_lru_cache_model.sv =====
// Top level of the set-associative LRU cache model.
//
// Input channel: i_in_valid / o_in_ready carry one byte address per transfer.
// Output channel: o_out_valid / i_out_ready carry one result per address:
// hit, evicted, set index (low 3 bits) and the saturating miss count.
// Each set is one row of a synchronous memory holding, per way, the valid
// bit, the recency rank and the tag. The set row is read on the edge that
// accepts the address; in the lookup state all ways are compared, and once
// the result register is free the updated row is written back and the
// output register is loaded, raising o_out_valid.
// A new address is accepted only after the previous row is written back
// (read-modify-write of the set row), so no forwarding is needed.
// Reset: synchronous, active low. After reset a clearing pass writes every
// row to invalid, during which no address is accepted.
// A stalled receiver holds the result register; one more address may be
// accepted and read, then it waits in the lookup state until the result
// register frees up.
module set_assoc_lru_cache_model #(
    parameter int LINE_SIZE    = 64,
    parameter int NUM_SETS     = 8,
    parameter int NUM_WAYS     = 4,
    parameter int ADDRESS_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_byte_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic        o_evicted,
    output logic [2:0]  o_set_used,
    output logic [31:0] o_miss_total
);

    // LINE_SIZE and NUM_SETS must be powers of two; the block does not enforce this
    localparam int AW       = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int OFF_W    = $clog2(LINE_SIZE);
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int SET_IW   = (SET_W > 0) ? SET_W : 1;
    localparam int TAG_RAW  = AW - OFF_W - SET_W;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int RANK_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W    = NUM_WAYS * (1 + RANK_W + TAG_W);
    localparam logic [31:0] ADDR_MASK = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF
                                        : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

    slru_pkg::t_state   r_state, n_state;
    logic [SET_IW-1:0]  r_clr_idx;
    logic [SET_IW-1:0]  r_set;
    logic [TAG_W-1:0]   r_tag;
    logic [31:0]        r_miss_cnt, n_miss_cnt;
    logic               r_out_valid;
    logic               r_hit;
    logic               r_evicted;
    logic [2:0]         r_set_used;

    logic [ROW_W-1:0]   r_mem [NUM_SETS];
    logic [ROW_W-1:0]   r_rd_row;

    logic [31:0]        in_line;
    logic [SET_IW-1:0]  in_set;
    logic [TAG_W-1:0]   in_tag;
    logic               in_xfer;
    logic               look_done;
    logic               slot_free;

    logic [NUM_WAYS-1:0]             rd_valid, wr_valid;
    logic [NUM_WAYS-1:0][RANK_W-1:0] rd_rank, wr_rank;
    logic [NUM_WAYS-1:0][TAG_W-1:0]  rd_tag, wr_tag;
    slru_pkg::t_lookup               look_res;

    // address split: line number, set index, tag
    assign in_line = (i_byte_address & ADDR_MASK) >> OFF_W;
    assign in_set  = SET_IW'(in_line % NUM_SETS);
    assign in_tag  = TAG_W'(in_line >> SET_W);

    assign o_in_ready = (r_state == slru_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign look_done  = (r_state == slru_pkg::S_LOOK) && slot_free;

    // set row memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_row <= r_mem[in_set];
        end
        if (r_state == slru_pkg::S_CLEAR) begin
            r_mem[r_clr_idx] <= '0;
        end else if (look_done) begin
            r_mem[r_set] <= {wr_valid, wr_rank, wr_tag};
        end
    end

    assign {rd_valid, rd_rank, rd_tag} = r_rd_row;

    slru_set_update #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W)
    ) u_set_update (
        .i_valid    (rd_valid),
        .i_rank     (rd_rank),
        .i_tag      (rd_tag),
        .i_look_tag (r_tag),
        .o_valid    (wr_valid),
        .o_rank     (wr_rank),
        .o_tag      (wr_tag),
        .o_res      (look_res)
    );

    // saturating miss count
    always_comb begin
        n_miss_cnt = r_miss_cnt;
        if (!look_res.hit && (r_miss_cnt != 32'hFFFF_FFFF)) begin
            n_miss_cnt = r_miss_cnt + 32'd1;
        end
    end

    // controller
    always_comb begin
        n_state = r_state;
        case (r_state)
            slru_pkg::S_CLEAR: begin
                if (r_clr_idx == SET_IW'(NUM_SETS - 1)) n_state = slru_pkg::S_IDLE;
            end
            slru_pkg::S_IDLE: begin
                if (in_xfer) n_state = slru_pkg::S_LOOK;
            end
            slru_pkg::S_LOOK: begin
                if (slot_free) n_state = slru_pkg::S_IDLE;
            end
            default: n_state = slru_pkg::S_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slru_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == slru_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_IW'(1);
            end
            if (look_done) begin
                r_miss_cnt  <= n_miss_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers; result fields load only when the result register frees up
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_set      <= in_set;
            r_tag      <= in_tag;
        end
        if (look_done) begin
            r_hit      <= look_res.hit;
            r_evicted  <= look_res.evicted;
            r_set_used <= 3'(r_set);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_evicted    = r_evicted;
    assign o_set_used   = r_set_used;
    assign o_miss_total = r_miss_cnt;

    // checks
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == slru_pkg::S_LOOK))
        else $error("accepted address did not enter lookup");

    a_miss_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_miss_cnt >= $past(r_miss_cnt)))
        else $error("miss count decreased");

    a_hit_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (look_done && look_res.hit) |=> $stable(r_miss_cnt))
        else $error("miss count changed on a hit");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        look_done |-> !(look_res.hit && look_res.evicted))
        else $error("hit reported with eviction");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the 4-way set-associative LRU cache model.
`timescale 1ns / 1ps

module testbench;

    localparam int LINE_SIZE    = 64;
    localparam int NUM_SETS     = 8;
    localparam int NUM_WAYS     = 4;
    localparam int ADDRESS_BITS = 32;
    localparam int OFFSET_BITS  = $clog2(LINE_SIZE);
    localparam int SET_BITS     = $clog2(NUM_SETS);
    localparam int TAG_BITS     = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
    localparam int NUM_LINES    = NUM_SETS * NUM_WAYS;
    localparam int RANDOM_ACCESSES = 2000;
    localparam int STUCK_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;

    // Receiver pacing modes
    typedef enum int {
        PACE_OPEN,
        PACE_HALF,
        PACE_SPARSE,
        PACE_MOSTLY
    } t_rx_pace;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [2:0]  set_used;
        logic [31:0] miss_total;
    } t_access_result;

    typedef struct {
        logic [31:0] addr;
        bit          wait_drain;
    } t_pending_access;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [31:0] in_addr = '0;
    logic        out_ready = 1'b0;
    wire         o_in_ready;
    wire         o_out_valid;
    wire         o_hit;
    wire         o_evicted;
    wire [2:0]   o_set_used;
    wire [31:0]  o_miss_total;

    // Shadow copy of the cache directory
    logic [TAG_BITS-1:0] line_tag [NUM_LINES];
    bit                  line_valid [NUM_LINES];
    int unsigned         line_rank [NUM_LINES];
    logic [31:0]         miss_count = '0;

    t_pending_access pending_q[$];
    t_access_result  expected_q[$];
    int n_sent = 0;
    int n_done = 0;
    int n_errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int pace_left = 0;
    t_rx_pace pace = PACE_OPEN;
    int stuck_cycles = 0;

    set_assoc_lru_cache_model #(
        .LINE_SIZE    (LINE_SIZE),
        .NUM_SETS     (NUM_SETS),
        .NUM_WAYS     (NUM_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_address (in_addr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_set_used     (o_set_used),
        .o_miss_total   (o_miss_total)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] line_addr(logic [TAG_BITS-1:0] tag_v, int unsigned set_idx,
                                              int unsigned offset);
        logic [SET_BITS-1:0]    set_bits;
        logic [OFFSET_BITS-1:0] off_bits;
        set_bits = set_idx[SET_BITS-1:0];
        off_bits = offset[OFFSET_BITS-1:0];
        return {tag_v, set_bits, off_bits};
    endfunction

    // Look up one address in the shadow directory and update LRU state
    function automatic t_access_result lookup_line(logic [31:0] addr);
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_BITS-1:0] tag_v;
        int base;
        int hit_way;
        int free_way;
        int lru_way;
        int victim;
        int unsigned age_limit;
        t_access_result r;
        set_idx  = addr[OFFSET_BITS +: SET_BITS];
        tag_v    = addr[OFFSET_BITS + SET_BITS +: TAG_BITS];
        base     = set_idx * NUM_WAYS;
        hit_way  = -1;
        free_way = -1;
        lru_way  = -1;
        r        = '0;
        r.set_used = set_idx;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (line_valid[base + w]) begin
                if (line_tag[base + w] == tag_v) hit_way = w;
                if (line_rank[base + w] == NUM_WAYS - 1) lru_way = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (hit_way >= 0) begin
            // hit: promote to MRU, age the ways that were more recent
            r.hit = 1'b1;
            victim = base + hit_way;
            age_limit = line_rank[victim];
        end else begin
            if (miss_count != 32'hFFFF_FFFF) miss_count++;
            if (free_way >= 0) begin
                victim = base + free_way;
                age_limit = NUM_WAYS;
            end else begin
                if (lru_way < 0) lru_way = 0;
                victim = base + lru_way;
                age_limit = NUM_WAYS - 1;
                r.evicted = 1'b1;
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (line_valid[base + w] && line_rank[base + w] < age_limit)
                line_rank[base + w]++;
        end
        line_valid[victim] = 1'b1;
        line_tag[victim]   = tag_v;
        line_rank[victim]  = 0;
        r.miss_total = miss_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Driver: bursts of addresses with random gaps; some items wait for a full drain
    always @(posedge i_clk) begin : drive_accesses
        t_pending_access next_item;
        bit fired;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fired = in_valid && o_in_ready;
            if (fired) begin
                expected_q.push_back(lookup_line(in_addr));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || fired) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].wait_drain || (!fired && n_sent == n_done))) begin
                    next_item = pending_q.pop_front();
                    in_valid <= 1'b1;
                    in_addr  <= next_item.addr;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver pacing, with one long hold-off to back the block up
    always @(posedge i_clk) begin : pace_results
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && n_done >= 150) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end else begin
            if (pace_left == 0) begin
                pace = t_rx_pace'($urandom_range(0, 3));
                pace_left = $urandom_range(20, 80);
            end else begin
                pace_left--;
            end
            case (pace)
                PACE_OPEN:   out_ready <= 1'b1;
                PACE_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
                PACE_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:     out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_access_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0b/%0b/%0d/%0d",
                         $time, o_hit, o_evicted, o_set_used, o_miss_total);
                n_errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("hit", 32'(want.hit), 32'(o_hit));
                check_field("evicted", 32'(want.evicted), 32'(o_evicted));
                check_field("set_used", 32'(want.set_used), 32'(o_set_used));
                check_field("miss_total", want.miss_total, o_miss_total);
            end
            n_done <= n_done + 1;
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin : watchdog
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TAG_BITS-1:0] tag_pool [6];
        t_pending_access item;
        logic [31:0] directed [$];

        foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = 0;
            line_tag[i]   = '0;
        end

        // Directed: address extremes, LRU fill and eviction order, every set
        directed = '{
            32'h0000_0000,
            line_addr(TAG_BITS'(0), 0, 63),
            32'hFFFF_FFFF,
            line_addr('1, 7, 0),
            line_addr(TAG_BITS'(1), 0, 5),
            line_addr(TAG_BITS'(2), 0, 17),
            line_addr(TAG_BITS'(3), 0, 40),
            line_addr(TAG_BITS'(0), 0, 1),
            line_addr(TAG_BITS'(4), 0, 2),
            line_addr(TAG_BITS'(1), 0, 3),
            line_addr(TAG_BITS'(3), 0, 62),
            line_addr(TAG_BITS'(2), 0, 9),
            line_addr(23'h2AAAAA, 1, 0),
            line_addr(23'h555555, 2, 63),
            line_addr(23'h2AAAAA, 3, 0),
            line_addr(23'h555555, 4, 63),
            line_addr(23'h2AAAAA, 5, 0),
            line_addr(23'h555555, 6, 63),
            line_addr(23'h2AAAAA, 1, 33),
            32'h8000_0000,
            32'h7FFF_FFFF,
            32'hFFFF_FFFF
        };
        foreach (directed[i]) begin
            item.addr = directed[i];
            item.wait_drain = (i == directed.size() - 1);
            pending_q.push_back(item);
        end

        // Random: mostly a small tag pool to force hits and evictions, some noise
        foreach (tag_pool[i]) tag_pool[i] = TAG_BITS'($urandom());
        for (int k = 0; k < RANDOM_ACCESSES; k++) begin
            if ($urandom_range(0, 99) < 5) tag_pool[$urandom_range(0, 5)] = TAG_BITS'($urandom());
            if ($urandom_range(0, 99) < 20)
                item.addr = $urandom();
            else
                item.addr = line_addr(tag_pool[$urandom_range(0, 5)], $urandom_range(0, 7),
                                      $urandom_range(0, 63));
            item.wait_drain = (k % 500 == 499);
            pending_q.push_back(item);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_q.size() != 0 || in_valid || n_sent != n_done);
        repeat (10) @(posedge i_clk);

        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived, expected %0d actual 0",
                     $time, expected_q.size(), expected_q.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
